FILE: hdl/mcob_pkg.sv
// ----------------------------------------------------------------------------
// mcob_pkg
// Shared constants and types of the matrix chain bracketing block.
// ----------------------------------------------------------------------------
package mcob_pkg;

  localparam int MAX_MATRICES = 16;
  localparam int DIM_BITS     = 8;
  localparam int DIM_SLOTS    = MAX_MATRICES + 1;
  localparam int IDX_W        = 4;
  localparam int CNT_W        = 5;
  localparam int COST_W       = 32;
  localparam int SYM_W        = 7;
  localparam int TBL_AW       = 2 * IDX_W;
  localparam int STACK_DEPTH  = 32;
  localparam int SP_W         = 6;
  localparam int PROD1_W      = 2 * DIM_BITS;
  localparam int PROD2_W      = 3 * DIM_BITS;

  localparam logic [SYM_W-1:0] SYM_OPEN   = 7'd40;
  localparam logic [SYM_W-1:0] SYM_CLOSE  = 7'd41;
  localparam logic [SYM_W-1:0] SYM_LETTER = 7'd65;
  localparam logic [COST_W-1:0] COST_MAX  = '1;

  typedef logic [DIM_BITS-1:0] dim_t;

  // traversal node: closing marker or a sub-chain [i..j]
  typedef struct packed {
    logic             close;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
  } node_t;

  // fill engine to emitter handoff
  typedef struct packed {
    logic              done;
    logic [COST_W-1:0] cost;
  } fill_stat_t;

endpackage

FILE: hdl/mcob_dim_if.sv
// ----------------------------------------------------------------------------
// mcob_dim_if
// Input channel: one chain dimension per item.
// ----------------------------------------------------------------------------
interface mcob_dim_if import mcob_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] dim_value;
  logic                last_dim;

  modport source (output valid, output dim_value, output last_dim, input ready);
  modport sink   (input valid, input dim_value, input last_dim, output ready);
endinterface

FILE: hdl/mcob_sym_if.sv
// ----------------------------------------------------------------------------
// mcob_sym_if
// Output channel: one bracketing symbol per item.
// ----------------------------------------------------------------------------
interface mcob_sym_if import mcob_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SYM_W-1:0]  symbol;
  logic [COST_W-1:0] min_cost;
  logic              chain_too_long;
  logic              last_symbol;

  modport source (output valid, output symbol, output min_cost, output chain_too_long,
                  output last_symbol, input ready);
  modport sink   (input valid, input symbol, input min_cost, input chain_too_long,
                  input last_symbol, output ready);
endinterface

FILE: hdl/mcob_dim_cell.sv
// ----------------------------------------------------------------------------
// mcob_dim_cell
// One cell of the dimension chain: holds a dimension, passes it on when
// a new one is shifted in.
// ----------------------------------------------------------------------------
module mcob_dim_cell import mcob_pkg::*; (
  input  logic clk_i,
  input  logic shift_i,
  input  dim_t d_i,
  output dim_t q_o
);

  dim_t dim_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      dim_q <= d_i;
    end
  end

  assign q_o = dim_q;

endmodule

FILE: hdl/mcob_fill.sv
// ----------------------------------------------------------------------------
// mcob_fill
// Dynamic-program engine: fills the cost and split tables one split candidate
// per read-multiply-accumulate pass and serves split reads to the emitter.
// ----------------------------------------------------------------------------
module mcob_fill import mcob_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CNT_W-1:0]  m_i,
  input  logic [CNT_W-1:0]  held_i,
  input  dim_t              taps_i [DIM_SLOTS],
  input  logic [TBL_AW-1:0] spl_addr_i,
  output logic [IDX_W-1:0]  spl_data_o,
  output fill_stat_t        stat_o
);

  typedef enum logic [1:0] {F_IDLE, F_RD, F_MUL, F_ACC} fstate_e;

  fstate_e            state_q;
  logic [CNT_W-1:0]   len_q, i_q, k_q;
  logic [COST_W-1:0]  best_q, cost_q;
  logic [IDX_W-1:0]   split_q;
  logic [PROD1_W-1:0] p1_q;
  logic [PROD2_W-1:0] p2_q;
  logic [COST_W:0]    csum_q;
  logic [COST_W-1:0]  c1_q, c2_q;
  logic               z1_q, z2_q, done_q;
  logic [IDX_W-1:0]   spl_rd_q;

  logic [COST_W-1:0]  cost_mem [MAX_MATRICES*MAX_MATRICES];
  logic [IDX_W-1:0]   split_mem [MAX_MATRICES*MAX_MATRICES];

  logic [CNT_W-1:0]   j_w, kp1_w, jp1_w;
  logic [COST_W+1:0]  t_w;
  logic [COST_W-1:0]  tsat_w, best_n;
  logic [IDX_W-1:0]   split_n;
  logic               take_w, last_k_w, wr_en;
  logic               more_i_w, more_len_w, done_n;
  logic [TBL_AW-1:0]  rd1_addr, rd2_addr, wr_addr;

  // dimension at chain position idx; newest dimension sits in the first cell
  function automatic dim_t dim_at(input dim_t taps [DIM_SLOTS],
                                  input logic [CNT_W-1:0] held,
                                  input logic [CNT_W-1:0] idx);
    logic [CNT_W-1:0] pos;
    pos = held - idx - CNT_W'(1);
    return taps[pos];
  endfunction

  always_comb begin
    j_w        = i_q + len_q - CNT_W'(1);
    kp1_w      = k_q + CNT_W'(1);
    jp1_w      = j_w + CNT_W'(1);
    rd1_addr   = {i_q[IDX_W-1:0], k_q[IDX_W-1:0]};
    rd2_addr   = {kp1_w[IDX_W-1:0], j_w[IDX_W-1:0]};
    wr_addr    = {i_q[IDX_W-1:0], j_w[IDX_W-1:0]};
    t_w        = {1'b0, csum_q} + (COST_W+2)'(p2_q);
    tsat_w     = (t_w > (COST_W+2)'(COST_MAX)) ? COST_MAX : t_w[COST_W-1:0];
    take_w     = (k_q == i_q) || (tsat_w < best_q);
    best_n     = take_w ? tsat_w : best_q;
    split_n    = take_w ? k_q[IDX_W-1:0] : split_q;
    last_k_w   = (kp1_w == j_w);
    wr_en      = (state_q == F_ACC) && last_k_w;
    more_i_w   = (i_q + len_q + CNT_W'(1) <= m_i);
    more_len_w = (len_q + CNT_W'(1) <= m_i);
    done_n     = ((state_q == F_IDLE) && start_i && (m_i < CNT_W'(2))) ||
                 (wr_en && !more_i_w && !more_len_w);
  end

  // table memories: one write port, registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cost_mem[wr_addr]  <= best_n;
      split_mem[wr_addr] <= split_n;
    end
    c1_q     <= cost_mem[rd1_addr];
    c2_q     <= cost_mem[rd2_addr];
    spl_rd_q <= split_mem[spl_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      done_q  <= 1'b0;
      len_q   <= '0;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      done_q <= done_n;
      unique case (state_q)
        F_IDLE: begin
          if (start_i) begin
            cost_q <= '0;
            len_q  <= CNT_W'(2);
            i_q    <= '0;
            k_q    <= '0;
            if (m_i >= CNT_W'(2)) begin
              state_q <= F_RD;
            end
          end
        end
        F_RD: begin
          z1_q    <= (i_q == k_q);
          z2_q    <= (kp1_w == j_w);
          p1_q    <= PROD1_W'(dim_at(taps_i, held_i, i_q)) *
                     PROD1_W'(dim_at(taps_i, held_i, kp1_w));
          state_q <= F_MUL;
        end
        F_MUL: begin
          p2_q    <= PROD2_W'(p1_q) * PROD2_W'(dim_at(taps_i, held_i, jp1_w));
          csum_q  <= (z1_q ? (COST_W+1)'(0) : {1'b0, c1_q}) +
                     (z2_q ? (COST_W+1)'(0) : {1'b0, c2_q});
          state_q <= F_ACC;
        end
        F_ACC: begin
          best_q  <= best_n;
          split_q <= split_n;
          if (!last_k_w) begin
            k_q     <= kp1_w;
            state_q <= F_RD;
          end else begin
            if (i_q == '0 && j_w == m_i - CNT_W'(1)) begin
              cost_q <= best_n;
            end
            if (more_i_w) begin
              i_q     <= i_q + CNT_W'(1);
              k_q     <= i_q + CNT_W'(1);
              state_q <= F_RD;
            end else if (more_len_w) begin
              len_q   <= len_q + CNT_W'(1);
              i_q     <= '0;
              k_q     <= '0;
              state_q <= F_RD;
            end else begin
              state_q <= F_IDLE;
            end
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign spl_data_o  = spl_rd_q;
  assign stat_o.done = done_q;
  assign stat_o.cost = cost_q;

endmodule

FILE: hdl/mcob_emit.sv
// ----------------------------------------------------------------------------
// mcob_emit
// Walks the split table with an explicit stack and sends the bracketing
// out one symbol per item.
// ----------------------------------------------------------------------------
module mcob_emit import mcob_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CNT_W-1:0]  m_i,
  input  logic [COST_W-1:0] cost_i,
  input  logic              ovf_i,
  output logic [TBL_AW-1:0] spl_addr_o,
  input  logic [IDX_W-1:0]  spl_data_i,
  output logic              done_o,
  mcob_sym_if.source        sym_out
);

  typedef enum logic [2:0] {E_IDLE, E_NODE, E_SPL, E_PUSH, E_POP, E_POPW} estate_e;

  estate_e           state_q;
  node_t             node_q, stk_rd_q;
  logic [SP_W-1:0]   sp_q;
  logic [IDX_W-1:0]  s_q;
  logic              done_q;
  logic              out_valid_q;
  logic [SYM_W-1:0]  sym_q;
  logic [COST_W-1:0] cost_q;
  logic              ovf_q, last_q;
  logic [COST_W-1:0] min_cost_q;
  logic              too_long_q;

  node_t             stack_mem [STACK_DEPTH];

  logic              free_w, leaf_w, push_en, load_w;
  logic [SP_W-1:0]   sp_m1;
  node_t             push_node;

  always_comb begin
    free_w     = !out_valid_q || sym_out.ready;
    load_w     = (state_q == E_NODE) && free_w;
    leaf_w     = node_q.close || (node_q.i == node_q.j);
    sp_m1      = sp_q - SP_W'(1);
    spl_addr_o = {node_q.i, node_q.j};
    push_en    = (state_q == E_SPL) || (state_q == E_PUSH);
    if (state_q == E_SPL) begin
      push_node = '{close: 1'b1, i: '0, j: '0};
    end else begin
      push_node = '{close: 1'b0, i: s_q + IDX_W'(1), j: node_q.j};
    end
  end

  // traversal stack
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem[sp_q[SP_W-2:0]] <= push_node;
    end
    stk_rd_q <= stack_mem[sp_m1[SP_W-2:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= E_IDLE;
      sp_q        <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= load_w && leaf_w && (sp_q == '0);
      if (load_w) begin
        out_valid_q <= 1'b1;
      end else if (sym_out.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        E_IDLE: begin
          if (start_i) begin
            node_q  <= '{close: 1'b0, i: '0, j: IDX_W'(m_i - CNT_W'(1))};
            sp_q    <= '0;
            cost_q  <= cost_i;
            ovf_q   <= ovf_i;
            state_q <= E_NODE;
          end
        end
        E_NODE: begin
          if (free_w) begin
            // payload is loaded together with valid so a waiting item stays put
            last_q     <= leaf_w && (sp_q == '0);
            min_cost_q <= cost_q;
            too_long_q <= ovf_q;
            if (node_q.close) begin
              sym_q <= SYM_CLOSE;
            end else if (leaf_w) begin
              sym_q <= SYM_LETTER + SYM_W'(node_q.i);
            end else begin
              sym_q <= SYM_OPEN;
            end
            if (!leaf_w) begin
              state_q <= E_SPL;
            end else if (sp_q == '0) begin
              state_q <= E_IDLE;
            end else begin
              state_q <= E_POP;
            end
          end
        end
        E_SPL: begin
          s_q     <= spl_data_i;
          sp_q    <= sp_q + SP_W'(1);
          state_q <= E_PUSH;
        end
        E_PUSH: begin
          sp_q    <= sp_q + SP_W'(1);
          node_q  <= '{close: 1'b0, i: node_q.i, j: s_q};
          state_q <= E_NODE;
        end
        E_POP: begin
          sp_q    <= sp_m1;
          state_q <= E_POPW;
        end
        E_POPW: begin
          node_q  <= stk_rd_q;
          state_q <= E_NODE;
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  assign done_o                 = done_q;
  assign sym_out.valid          = out_valid_q;
  assign sym_out.symbol         = sym_q;
  assign sym_out.min_cost       = min_cost_q;
  assign sym_out.chain_too_long = too_long_q;
  assign sym_out.last_symbol    = last_q;

endmodule

FILE: hdl/matrix_chain_order_bracketing_top.sv
// the last dimension item starts a table fill that steps through the read, multiply and
// accumulate states for each split candidate; each output symbol then takes the node state
// plus the split and push or the pop and pop-wait states, holding while the output is not taken.
// throughput: one dimension per cycle while loading; one chain at a time.
// reset clears the dimension count, overflow flag and all control state; the
// tables need no clearing.
// ----------------------------------------------------------------------------
// matrix_chain_order_bracketing_top
// Optimal matrix chain bracketing: loads dimensions into a cell chain, fills
// the cost and split tables, then emits the bracketing symbol by symbol.
// ----------------------------------------------------------------------------
module matrix_chain_order_bracketing_top import mcob_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcob_dim_if.sink   dim_in,
  mcob_sym_if.source sym_out
);

  typedef enum logic [1:0] {S_LOAD, S_FILL, S_EMIT} state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q, m_q;
  logic             ovf_q;
  logic             fill_start_q, emit_start_q;

  dim_t             taps [DIM_SLOTS];
  logic             accept_w, shift_w, ovf_n, fill_go_w;
  logic [CNT_W-1:0] cnt_n;
  logic [TBL_AW-1:0] spl_addr;
  logic [IDX_W-1:0] spl_data;
  fill_stat_t       fill_stat;
  logic             emit_done;

  always_comb begin
    accept_w  = dim_in.valid && dim_in.ready;
    shift_w   = accept_w && (cnt_q < CNT_W'(DIM_SLOTS));
    cnt_n     = shift_w ? cnt_q + CNT_W'(1) : cnt_q;
    ovf_n     = ovf_q || (accept_w && !shift_w);
    fill_go_w = (state_q == S_LOAD) && accept_w && dim_in.last_dim && (cnt_n >= CNT_W'(2));
  end

  assign dim_in.ready = (state_q == S_LOAD);

  for (genvar g = 0; g < DIM_SLOTS; g++) begin : g_cell
    if (g == 0) begin : g_head
      mcob_dim_cell u_cell (.clk_i, .shift_i(shift_w), .d_i(dim_in.dim_value), .q_o(taps[g]));
    end else begin : g_body
      mcob_dim_cell u_cell (.clk_i, .shift_i(shift_w), .d_i(taps[g-1]), .q_o(taps[g]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      cnt_q        <= '0;
      m_q          <= '0;
      ovf_q        <= 1'b0;
      fill_start_q <= 1'b0;
      emit_start_q <= 1'b0;
    end else begin
      fill_start_q <= fill_go_w;
      emit_start_q <= (state_q == S_FILL) && fill_stat.done;
      unique case (state_q)
        S_LOAD: begin
          if (accept_w) begin
            // a final item that leaves fewer than two dimensions ends the chain
            if (dim_in.last_dim && (cnt_n < CNT_W'(2))) begin
              cnt_q <= '0;
              ovf_q <= 1'b0;
            end else begin
              cnt_q <= cnt_n;
              ovf_q <= ovf_n;
            end
            if (fill_go_w) begin
              m_q     <= cnt_n - CNT_W'(1);
              state_q <= S_FILL;
            end
          end
        end
        S_FILL: begin
          if (fill_stat.done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_done) begin
            cnt_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= S_LOAD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  mcob_fill u_fill (
    .clk_i,
    .rst_ni,
    .start_i    (fill_start_q),
    .m_i        (m_q),
    .held_i     (cnt_q),
    .taps_i     (taps),
    .spl_addr_i (spl_addr),
    .spl_data_o (spl_data),
    .stat_o     (fill_stat)
  );

  mcob_emit u_emit (
    .clk_i,
    .rst_ni,
    .start_i    (emit_start_q),
    .m_i        (m_q),
    .cost_i     (fill_stat.cost),
    .ovf_i      (ovf_q),
    .spl_addr_o (spl_addr),
    .spl_data_i (spl_data),
    .done_o     (emit_done),
    .sym_out    (sym_out)
  );

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DIM_SLOTS)) else $error("dimension count out of range");

  a_fill_done_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_stat.done |-> state_q == S_FILL) else $error("fill done outside fill phase");

  a_emit_done_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_done |-> state_q == S_EMIT) else $error("emit done outside emit phase");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_start_q |=> !dim_in.ready) else $error("input taken during table fill");

endmodule

FILE: sim/tb_matrix_chain_order_bracketing_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_chain_order_bracketing_top
// Feeds chains of matrix dimensions, under random idling on both sides in all
// but the last phase. For each chain of two or more dimensions it works out the
// optimal bracketing and its cost, then checks every emitted symbol in order.
// ----------------------------------------------------------------------------
module tb_matrix_chain_order_bracketing_top;
  import mcob_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol;
    logic [COST_W-1:0] cost;
    logic              too_long;
    logic              last;
  } bracket_sym_t;

  class bracket_scoreboard;
    dim_t         chain_dims[$];
    logic         dropped;
    bracket_sym_t bracket_q[$];
    int           errors;
    int           chains;
    int           symbols;

    function new();
      dropped = 1'b0;
      errors  = 0;
      chains  = 0;
      symbols = 0;
    endfunction

    // builds the bracketing of the chain held so far
    function void solve_chain();
      longint unsigned cost[MAX_MATRICES][MAX_MATRICES];
      int              split[MAX_MATRICES][MAX_MATRICES];
      int              m, len, i, j, k;
      longint unsigned t;
      node_t           stk[2*MAX_MATRICES+2];
      int              sp;
      node_t           nd;
      bracket_sym_t    s;
      m = chain_dims.size() - 1;
      for (i = 0; i < m; i++) cost[i][i] = 0;
      for (len = 2; len <= m; len++) begin
        for (i = 0; i + len <= m; i++) begin
          j = i + len - 1;
          for (k = i; k < j; k++) begin
            t = longint'(chain_dims[i]) * chain_dims[k+1] * chain_dims[j+1]
                + cost[i][k] + cost[k+1][j];
            if (t > COST_MAX) t = COST_MAX;
            // strict less keeps the lowest split on a tie
            if (k == i || t < cost[i][j]) begin
              cost[i][j]  = t;
              split[i][j] = k;
            end
          end
        end
      end
      sp = 0;
      stk[sp] = '{close: 1'b0, i: 0, j: IDX_W'(m - 1)};
      sp++;
      while (sp > 0) begin
        sp--;
        nd = stk[sp];
        s.cost     = cost[0][m-1][COST_W-1:0];
        s.too_long = dropped;
        s.last     = 1'b0;
        if (nd.close) begin
          s.symbol = SYM_CLOSE;
        end else if (nd.i == nd.j) begin
          s.symbol = SYM_LETTER + SYM_W'(nd.i);
        end else begin
          s.symbol = SYM_OPEN;
          stk[sp] = '{close: 1'b1, i: 0, j: 0};
          sp++;
          stk[sp] = '{close: 1'b0, i: IDX_W'(split[nd.i][nd.j] + 1), j: nd.j};
          sp++;
          stk[sp] = '{close: 1'b0, i: nd.i, j: IDX_W'(split[nd.i][nd.j])};
          sp++;
        end
        bracket_q.insert(bracket_q.size(), s);
      end
      bracket_q[bracket_q.size()-1].last = 1'b1;
    endfunction

    function void note_dim(dim_t d, logic last);
      if (chain_dims.size() < DIM_SLOTS) chain_dims.insert(chain_dims.size(), d);
      else dropped = 1'b1;
      if (last) begin
        if (chain_dims.size() >= 2) begin
          solve_chain();
          chains++;
        end
        chain_dims.delete();
        dropped = 1'b0;
      end
    endfunction

    function void check_symbol(bracket_sym_t got);
      bracket_sym_t want;
      symbols++;
      if (bracket_q.size() == 0) begin
        $display("%0t: unexpected symbol, expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      want = bracket_q.pop_front();
      if (got.symbol !== want.symbol)
        $display("%0t: symbol expected %0d actual %0d", $realtime, want.symbol, got.symbol);
      if (got.cost !== want.cost)
        $display("%0t: min_cost expected %0d actual %0d", $realtime, want.cost, got.cost);
      if (got.too_long !== want.too_long)
        $display("%0t: chain_too_long expected %b actual %b", $realtime, want.too_long,
                 got.too_long);
      if (got.last !== want.last)
        $display("%0t: last_symbol expected %b actual %b", $realtime, want.last, got.last);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mcob_dim_if dim_in ();
  mcob_sym_if sym_out ();

  matrix_chain_order_bracketing_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dim_in (dim_in.sink),
    .sym_out(sym_out.source)
  );

  bracket_scoreboard sb = new();
  int send_idle_pct = 31;
  int take_idle_pct = 68;
  int dims_sent     = 0;

  always #4 clk_i = ~clk_i;

  initial begin
    dim_in.valid     = 1'b0;
    dim_in.dim_value = '0;
    dim_in.last_dim  = 1'b0;
    sym_out.ready    = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) sym_out.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && sym_out.valid && sym_out.ready)
      sb.check_symbol('{symbol: sym_out.symbol, cost: sym_out.min_cost,
                        too_long: sym_out.chain_too_long, last: sym_out.last_symbol});
  end

  task automatic send_dim(input dim_t d, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      dim_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    dim_in.valid     <= 1'b1;
    dim_in.dim_value <= d;
    dim_in.last_dim  <= last;
    do @(posedge clk_i); while (!dim_in.ready);
    sb.note_dim(d, last);
    dims_sent++;
  endtask

  task automatic send_chain(input int len, input int mode);
    dim_t d;
    for (int n = 0; n < len; n++) begin
      case (mode)
        1: d = 8'd255;
        2: d = 8'd0;
        3: d = (n % 2) ? 8'd1 : 8'd255;
        default: d = dim_t'($urandom_range(255));
      endcase
      send_dim(d, n == len - 1);
    end
  endtask

  initial begin
    int len;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single dimension, shortest chain, extremes, full and overlong chains
    send_chain(1, 0);
    send_chain(2, 1);
    send_chain(3, 2);
    send_chain(4, 3);
    send_chain(DIM_SLOTS, 1);
    send_chain(DIM_SLOTS + 2, 0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 68 : 0;
      take_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 31 : 0;
      for (int c = 0; c < 20; c++) begin
        // mostly short chains, now and then full or overlong ones
        case ($urandom_range(9))
          0: len = 1;
          1: len = $urandom_range(DIM_SLOTS + 3, DIM_SLOTS);
          default: len = $urandom_range(8, 2);
        endcase
        send_chain(len, ($urandom_range(7) == 0) ? $urandom_range(3, 1) : 0);
      end
    end
    dim_in.valid <= 1'b0;

    while (sb.bracket_q.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);

    $display("covered %0d dimensions, %0d bracketed chains, %0d symbols checked",
             dims_sent, sb.chains, sb.symbols);
    if (sb.errors == 0 && sb.bracket_q.size() == 0) begin
      $display("tb_matrix_chain_order_bracketing_top: clean");
    end else begin
      $display("tb_matrix_chain_order_bracketing_top: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d symbols outstanding", sb.bracket_q.size());
    $display("tb_matrix_chain_order_bracketing_top: errors");
    $finish;
  end

endmodule

FILE: matrix_chain_order_bracketing_top.f
hdl/mcob_pkg.sv
hdl/mcob_dim_if.sv
hdl/mcob_sym_if.sv
hdl/mcob_dim_cell.sv
hdl/mcob_fill.sv
hdl/mcob_emit.sv
hdl/matrix_chain_order_bracketing_top.sv
sim/tb_matrix_chain_order_bracketing_top.sv
